// ----- rtl/core/sstd_pkg.sv -----
// shared types, codes and the segment font for the seven-segment text display
package sstd_pkg;

    localparam int DIGITS_DEF = 4;
    localparam int DIGITS_MAX = 8;
    localparam int ENABLE_W   = 4;
    localparam int SEG_W      = 8;
    localparam int MODE_W     = 2;
    localparam int BYTE_W     = 8;

    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [BYTE_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

    typedef struct packed {
        logic       valid;
        logic       dot;
        logic [3:0] value;
    } slot_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    // segments a..g in bits 0..6, 1 lit
    function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] value);
        logic [SEG_W-1:0] seg;
        case (value)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/core/sstd_cell.sv -----
// one character slot of the display shift chain
module sstd_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  sstd_pkg::cell_ctrl_t ctrl,
    input  logic                set_dot,
    input  sstd_pkg::slot_t     shift_in,
    output sstd_pkg::slot_t     slot_q,
    output sstd_pkg::slot_t     slot_d
);

    sstd_pkg::slot_t slot_reg;
    sstd_pkg::slot_t slot_next;

    always_comb begin
        slot_next = slot_reg;
        if (ctrl.clear) begin
            slot_next = '0;
        end else if (ctrl.shift) begin
            slot_next = shift_in;
        end else if (set_dot) begin
            slot_next.dot = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else begin
            slot_reg <= slot_next;
        end
    end

    assign slot_q = slot_reg;
    assign slot_d = slot_next;

endmodule

// ----- rtl/core/sstd_drive.sv -----
// scanned slot select and segment / enable decode
module sstd_drive #(
    parameter int DIGITS = sstd_pkg::DIGITS_DEF,
    parameter int POS_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
    input  sstd_pkg::slot_t                  slots [DIGITS],
    input  logic [POS_W-1:0]                 pos,
    output logic [sstd_pkg::ENABLE_W-1:0]    digit_enable_n,
    output logic [sstd_pkg::SEG_W-1:0]       segments
);

    sstd_pkg::slot_t sel;

    always_comb begin
        sel = '0;
        for (int i = 0; i < DIGITS; i++) begin
            if (pos == POS_W'(i)) begin
                sel = slots[i];
            end
        end
    end

    always_comb begin
        segments = '0;
        if (sel.valid) begin
            segments = sstd_pkg::seg_font(sel.value);
        end
        segments[sstd_pkg::SEG_W-1] = sel.dot;
    end

    always_comb begin
        digit_enable_n = '1;
        if (int'(pos) < sstd_pkg::ENABLE_W) begin
            digit_enable_n = ~(sstd_pkg::ENABLE_W'(1) << pos);
        end
    end

endmodule

// ----- rtl/core/seven_segment_text_display.sv -----
// top level of the multiplexed seven-segment text display driver
//
//  channel | dir | tdata                                   | tuser
//  --------+-----+-----------------------------------------+-------------------
//  s_      | in  | [7:0] byte_value                        | [1:0] mode
//  m_      | out | [3:0] digit_enable_n, [11:4] segments   | -
//
// one transfer per cycle on both sides unless stalled: every input transfer
// gives one result, computed in the same cycle, held in one output register
// aresetn (synchronous, low) empties the slot chain and sets the scan position
// to the last position
// a stalled result holds the output register; s_tready stays high as long as
// the output register is empty or is being taken in the same cycle
module seven_segment_text_display #(
    parameter int DIGITS = sstd_pkg::DIGITS_DEF,
    parameter int POS_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] byte_value
    input  logic [1:0]  s_tuser,    // [1:0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [3:0] digit_enable_n, [11:4] segments, [15:12] zero
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);

    logic fire;
    logic is_digit;
    logic dot_cmd;

    sstd_pkg::cell_ctrl_t ctrl;
    sstd_pkg::slot_t      new_slot;
    sstd_pkg::slot_t      slot_q [DIGITS];
    sstd_pkg::slot_t      slot_d [DIGITS];

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    logic [sstd_pkg::ENABLE_W-1:0] enable_n;
    logic [sstd_pkg::SEG_W-1:0]    seg;

    logic        m_valid_reg;
    logic        m_valid_next;
    logic [15:0] m_data_reg;

    // the output register frees up when its result is taken
    assign s_tready = !m_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    // text byte decode
    assign is_digit = (s_tdata >= sstd_pkg::CHAR_ZERO) && (s_tdata <= sstd_pkg::CHAR_NINE);
    assign dot_cmd  = fire && (s_tuser == sstd_pkg::MODE_TEXT)
                      && (s_tdata == sstd_pkg::CHAR_DOT);

    assign ctrl.clear = fire && (s_tuser == sstd_pkg::MODE_CLEAR);
    assign ctrl.shift = fire && (s_tuser == sstd_pkg::MODE_TEXT) && is_digit;

    // a new digit enters on the right, dot off
    always_comb begin
        new_slot       = '0;
        new_slot.valid = 1'b1;
        new_slot.value = 4'(s_tdata - sstd_pkg::CHAR_ZERO);
    end

    // slot chain: cell i takes from cell i+1, the last cell from the byte stream
    for (genvar i = 0; i < DIGITS; i++) begin : g_cell
        sstd_pkg::slot_t shift_in;
        logic            set_dot;

        if (i == DIGITS - 1) begin : g_last
            assign shift_in = new_slot;
            assign set_dot  = dot_cmd;
        end else begin : g_inner
            assign shift_in = slot_q[i+1];
            assign set_dot  = 1'b0;
        end

        sstd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .set_dot  (set_dot),
            .shift_in (shift_in),
            .slot_q   (slot_q[i]),
            .slot_d   (slot_d[i])
        );
    end

    // scan position, wraps after the last position
    always_comb begin
        pos_next = pos_reg;
        if (fire && (s_tuser == sstd_pkg::MODE_TICK)) begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= LAST_POS;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // result reflects the state after this item
    sstd_drive #(
        .DIGITS (DIGITS),
        .POS_W  (POS_W)
    ) u_drive (
        .slots          (slot_d),
        .pos            (pos_next),
        .digit_enable_n (enable_n),
        .segments       (seg)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= {4'b0, seg, enable_n};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/core/sstd_checker.sv -----
// port-level checks for the seven-segment text display, bound to the top level
module sstd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // every input transfer gives a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("input transfer without result");

    // input is never blocked while the result side is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // at most one position enabled, padding bits zero
    a_enable_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($onehot0(~m_tdata[3:0]) && (m_tdata[15:12] == 4'b0)))
        else $error("bad enable pattern or padding");

endmodule

bind seven_segment_text_display sstd_checker u_sstd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/seven_segment_text_display_test.sv -----
// self-checking testbench for the seven-segment text display driver
module seven_segment_text_display_test;

    import sstd_pkg::*;

    localparam int DIGITS       = 4;
    localparam logic [1:0] LAST_POS = 2'(DIGITS - 1);
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;   // unused code, state kept
    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [ENABLE_W-1:0] enable_n;
        logic [SEG_W-1:0]    segments;
    } drive_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // [7:0] byte_value
    logic [1:0]  s_tuser  = '0;     // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [3:0] digit_enable_n, [11:4] segments

    // predictor state
    slot_t       display_slots [DIGITS];
    logic [1:0]  scan_pos;
    drive_t      pending_drives [$];
    drive_t      want;

    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left  = 0;
    int          stall_left  = 0;
    int          stall_kind  = 0;

    seven_segment_text_display u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: runs of always-ready, random stalls and a periodic stall
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 2);
            stall_left = $urandom_range(8, 64);
        end
        stall_left = stall_left - 1;
        case (stall_kind)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 2) != 0);
            default: m_tready <= (cycle_count % 5 < 2);
        endcase
    end

    // the next drive pattern after one input transfer
    function automatic drive_t next_drive(input logic [1:0] mode, input logic [7:0] value);
        drive_t d;
        slot_t  cur;
        case (mode)
            MODE_TICK: begin
                scan_pos = (scan_pos == LAST_POS) ? 2'd0 : scan_pos + 2'd1;
            end
            MODE_TEXT: begin
                if (value >= CHAR_ZERO && value <= CHAR_NINE) begin
                    for (int i = 0; i < DIGITS - 1; i++)
                        display_slots[i] = display_slots[i + 1];
                    display_slots[LAST_POS] = {1'b1, 1'b0, 4'(value - CHAR_ZERO)};
                end else if (value == CHAR_DOT) begin
                    display_slots[LAST_POS].dot = 1'b1;
                end
            end
            MODE_CLEAR: begin
                for (int i = 0; i < DIGITS; i++)
                    display_slots[i] = '0;
            end
            default: ;
        endcase
        cur = display_slots[scan_pos];
        d.segments = '0;
        if (cur.valid) begin
            case (cur.value)
                4'd0:    d.segments = 8'h3F;
                4'd1:    d.segments = 8'h06;
                4'd2:    d.segments = 8'h5B;
                4'd3:    d.segments = 8'h4F;
                4'd4:    d.segments = 8'h66;
                4'd5:    d.segments = 8'h6D;
                4'd6:    d.segments = 8'h7D;
                4'd7:    d.segments = 8'h07;
                4'd8:    d.segments = 8'h7F;
                4'd9:    d.segments = 8'h6F;
                default: d.segments = 8'h00;
            endcase
        end
        d.segments[7] = cur.dot;
        d.enable_n    = ~(4'b0001 << scan_pos);
        return d;
    endfunction

    // one input transfer, with a random gap at the start of each burst
    task automatic send_item(input logic [1:0] mode, input logic [7:0] value);
        int gap;
        bit taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        pending_drives.push_back(next_drive(mode, value));
    endtask

    // hold the sender until every expected pattern has come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_drives.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // result checker: the transfer happens at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_drives.size() == 0) begin
                $display("%0t: result with none expected, m_tdata %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_drives.pop_front();
                if (m_tdata[3:0] !== want.enable_n) begin
                    $display("%0t: digit_enable_n expected %h actual %h",
                             $time, want.enable_n, m_tdata[3:0]);
                    error_count++;
                end
                if (m_tdata[11:4] !== want.segments) begin
                    $display("%0t: segments expected %h actual %h",
                             $time, want.segments, m_tdata[11:4]);
                    error_count++;
                end
            end
        end
    end

    // scan through all positions of the empty display, including the wrap
    task automatic test_empty_scan();
        repeat (DIGITS + 1) send_item(MODE_TICK, 8'hFF);
        send_item(MODE_TICK, 8'h00);
    endtask

    // dot before any digit, digit overflow, byte edges next to the digit range
    task automatic test_text_cases();
        send_item(MODE_TEXT, CHAR_DOT);
        send_item(MODE_TICK, 8'h00);
        for (int i = 1; i <= 5; i++)
            send_item(MODE_TEXT, CHAR_ZERO + 8'(i));
        send_item(MODE_TEXT, CHAR_DOT);
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'hFF);
        send_item(MODE_TEXT, CHAR_ZERO - 8'd1);
        send_item(MODE_TEXT, CHAR_NINE + 8'd1);
        send_item(MODE_TEXT, CHAR_ZERO);
        send_item(MODE_TEXT, CHAR_NINE);
        send_item(MODE_TICK, 8'h55);
        send_item(MODE_TICK, 8'hAA);
    endtask

    // unused mode keeps the state, clear empties every slot and dot
    task automatic test_clear_and_spare();
        send_item(MODE_SPARE, 8'hFF);
        send_item(MODE_SPARE, CHAR_ZERO);
        send_item(MODE_CLEAR, CHAR_NINE);
        send_item(MODE_TICK, 8'h00);
        send_item(MODE_CLEAR, 8'hFF);
    endtask

    // random messages: mostly clear followed by digits, dots and ticks
    task automatic test_random_messages();
        int counted;
        int pick;
        bit paused;
        logic [1:0] m;
        logic [7:0] b;
        counted = 0;
        paused  = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                send_item(MODE_CLEAR, 8'($urandom));
                counted++;
                repeat ($urandom_range(1, 12)) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) begin
                        send_item(MODE_TEXT, CHAR_ZERO + 8'($urandom_range(0, 9)));
                        counted++;
                    end else if (pick < 60) begin
                        send_item(MODE_TEXT, CHAR_DOT);
                        counted++;
                    end else if (pick < 92) begin
                        send_item(MODE_TICK, 8'($urandom));
                        counted++;
                    end else begin
                        send_item(MODE_TEXT, 8'($urandom_range(0, 255)));
                        counted++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    m = 2'($urandom_range(0, 3));
                    b = 8'($urandom_range(0, 255));
                    send_item(m, b);
                    counted++;
                end
            end
            if (!paused && counted >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                wait_idle();
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DIGITS; i++)
            display_slots[i] = '0;
        scan_pos = LAST_POS;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_scan();
        test_text_cases();
        wait_idle();
        test_clear_and_spare();
        wait_idle();
        test_random_messages();
        wait_idle();
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
